// ===== rtl/trpi_pkg.sv =====
// ----------------------------------------------------------------------------
// trpi_pkg
// Shared types and codes for the tied-rank podium insert block: the input
// and result transaction structs, operation and status codes, and the small
// control structs that run along the chain of row cells.
// ----------------------------------------------------------------------------
package trpi_pkg;

  // Default geometry of the podium.
  localparam int unsigned ROWS_DEF  = 4;
  localparam int unsigned SEATS_DEF = 4;

  // Width of a player index and of a row score.
  localparam int unsigned PLAYER_W = 2;
  localparam int unsigned SCORE_W  = 16;

  // Operation codes carried in the input transaction.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PLACED  = 3'd0,
    ST_BELOW   = 3'd1,
    ST_FULL    = 3'd2,
    ST_SKIPPED = 3'd3,
    ST_DONE    = 3'd4
  } status_e;

  // Input transaction.
  typedef struct packed {
    logic [1:0]          operation;
    logic [PLAYER_W-1:0] player;
    logic [SCORE_W-1:0]  score;
    logic                enabled;
    logic [1:0]          row_select;
  } in_t;

  // Result transaction.
  typedef struct packed {
    status_e             status;
    logic [1:0]          placed_row;
    logic [1:0]          placed_seat;
    logic [SCORE_W-1:0]  row_score;
    logic [3:0]          seat_valid;
    logic [PLAYER_W-1:0] seat_0;
    logic [PLAYER_W-1:0] seat_1;
    logic [PLAYER_W-1:0] seat_2;
    logic [PLAYER_W-1:0] seat_3;
  } out_t;

  // Command broadcast to every row cell in the execute cycle.
  typedef struct packed {
    logic                clear;
    logic                insert;
    logic [PLAYER_W-1:0] player;
    logic [SCORE_W-1:0]  score;
  } cell_cmd_t;

  // Flags handed from one cell to the cell below it.
  typedef struct packed {
    logic found;  // some row above has a score at or below the new one
    logic shift;  // a new row was opened above, so this row moves down
  } cell_chain_t;

  // What a cell reports back about the current insert.
  typedef struct packed {
    logic hit;     // this is the row the player lands on
    logic opened;  // a new row opens here
    logic full;    // equal row with no empty seat
  } cell_flags_t;

endpackage

// ===== rtl/trpi_cell.sv =====
// ----------------------------------------------------------------------------
// trpi_cell
// One row of the podium: its score, seat occupancy and seated players. The
// cell compares the insert score with its own, passes the search and shift
// flags to the row below, and takes over the row above when a new row opens.
// ----------------------------------------------------------------------------
module trpi_cell #(
  parameter int unsigned SEATS = trpi_pkg::SEATS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  trpi_pkg::cell_cmd_t                        cmd_i,
  input  trpi_pkg::cell_chain_t                      chain_i,
  input  logic [trpi_pkg::SCORE_W-1:0]               prev_score_i,
  input  logic [SEATS-1:0]                           prev_occ_i,
  input  logic [SEATS-1:0][trpi_pkg::PLAYER_W-1:0]   prev_players_i,
  output trpi_pkg::cell_chain_t                      chain_o,
  output trpi_pkg::cell_flags_t                      flags_o,
  output logic [((SEATS > 1) ? $clog2(SEATS) : 1)-1:0] seat_idx_o,
  output logic [trpi_pkg::SCORE_W-1:0]               score_o,
  output logic [SEATS-1:0]                           occ_o,
  output logic [SEATS-1:0][trpi_pkg::PLAYER_W-1:0]   players_o
);
  import trpi_pkg::*;

  localparam int unsigned SEAT_W = (SEATS > 1) ? $clog2(SEATS) : 1;

  logic [SCORE_W-1:0]               score_q, score_d;
  logic [SEATS-1:0]                 occ_q, occ_d;
  logic [SEATS-1:0][PLAYER_W-1:0]   players_q, players_d;
  logic                             ge, eq, hit, open_row, has_free;
  logic [SEAT_W-1:0]                free_idx;

  // Compare against the insert score and find the landing row.
  assign ge       = (cmd_i.score >= score_q);
  assign eq       = (cmd_i.score == score_q);
  assign hit      = cmd_i.insert && ge && !chain_i.found;
  assign open_row = hit && !eq;

  assign chain_o.found = chain_i.found || ge;
  assign chain_o.shift = chain_i.shift || open_row;

  // First empty seat of this row.
  always_comb begin
    free_idx = '0;
    has_free = 1'b0;
    for (int s = SEATS - 1; s >= 0; s--) begin
      if (!occ_q[s]) begin
        free_idx = SEAT_W'(s);
        has_free = 1'b1;
      end
    end
  end

  assign flags_o.hit    = hit;
  assign flags_o.opened = open_row;
  assign flags_o.full   = hit && eq && !has_free;
  assign seat_idx_o     = free_idx;

  // Next row contents.
  always_comb begin
    score_d   = score_q;
    occ_d     = occ_q;
    players_d = players_q;
    priority if (cmd_i.clear) begin
      score_d = '0;
      occ_d   = '0;
    end else if (open_row) begin
      score_d      = cmd_i.score;
      occ_d        = '0;
      occ_d[0]     = 1'b1;
      players_d[0] = cmd_i.player;
    end else if (cmd_i.insert && chain_i.shift) begin
      score_d   = prev_score_i;
      occ_d     = prev_occ_i;
      players_d = prev_players_i;
    end else if (hit && has_free) begin
      occ_d[free_idx]     = 1'b1;
      players_d[free_idx] = cmd_i.player;
    end else begin
      // The row keeps its contents.
      score_d = score_q;
    end
  end

  // Row score and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= '0;
      occ_q   <= '0;
    end else begin
      score_q <= score_d;
      occ_q   <= occ_d;
    end
  end

  // Seated players; an empty seat is never read.
  always_ff @(posedge clk_i) begin
    players_q <= players_d;
  end

  assign score_o   = score_q;
  assign occ_o     = occ_q;
  assign players_o = players_q;

endmodule

// ===== rtl/tied_rank_podium_insert_top.sv =====
// ----------------------------------------------------------------------------
// tied_rank_podium_insert_top
// Descending podium of ROWS rows with SEATS tied seats each, built as a chain
// of row cells that share one command and pass search and shift flags down.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_data_i) takes one
//   transaction: clear, insert or read. Every transaction returns exactly one
//   result transaction on the output channel (out_valid_o / out_ready_i /
//   out_data_o), in order.
//   The transaction is captured at acceptance and executed by all row cells
//   once the result register is free to take a result; the execute cycle
//   also loads the result register, which then shows the result.
//   No new transaction is accepted until the held one executes; the single
//   command register holds one transaction from acceptance until it executes.
//   A stalled receiver holds the result register; a second transaction is
//   still accepted and waits in the command register until the result is
//   taken.
//   Reset empties every seat and sets every row score to zero; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module tied_rank_podium_insert_top #(
  parameter int unsigned ROWS  = trpi_pkg::ROWS_DEF,
  parameter int unsigned SEATS = trpi_pkg::SEATS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  trpi_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output trpi_pkg::out_t out_data_o
);
  import trpi_pkg::*;

  localparam int unsigned SEAT_W = (SEATS > 1) ? $clog2(SEATS) : 1;

  logic        busy_q;
  in_t         item_q;
  logic        out_valid_q;
  out_t        out_q, out_d;
  logic        exec;
  cell_cmd_t   cmd;

  cell_chain_t                      chain    [ROWS+1];
  cell_flags_t                      flags    [ROWS];
  logic [SEAT_W-1:0]                seat_idx [ROWS];
  logic [SCORE_W-1:0]               score    [ROWS];
  logic [SEATS-1:0]                 occ      [ROWS];
  logic [SEATS-1:0][PLAYER_W-1:0]   players  [ROWS];

  // Command register: one transaction waits here until it executes.
  assign in_ready_o = !busy_q;
  assign exec       = busy_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      busy_q <= 1'b1;
    end else if (exec) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  // Command broadcast to the row cells in the execute cycle.
  assign cmd.clear  = exec && (item_q.operation == OP_CLEAR);
  assign cmd.insert = exec && (item_q.operation == OP_INSERT) && item_q.enabled;
  assign cmd.player = item_q.player;
  assign cmd.score  = item_q.score;

  assign chain[0] = '0;

  // Chain of row cells, top row first.
  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic [SCORE_W-1:0]             prev_score;
    logic [SEATS-1:0]               prev_occ;
    logic [SEATS-1:0][PLAYER_W-1:0] prev_players;

    if (r == 0) begin : g_first
      assign prev_score   = '0;
      assign prev_occ     = '0;
      assign prev_players = '0;
    end else begin : g_next
      assign prev_score   = score[r-1];
      assign prev_occ     = occ[r-1];
      assign prev_players = players[r-1];
    end

    trpi_cell #(
      .SEATS(SEATS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .chain_i        (chain[r]),
      .prev_score_i   (prev_score),
      .prev_occ_i     (prev_occ),
      .prev_players_i (prev_players),
      .chain_o        (chain[r+1]),
      .flags_o        (flags[r]),
      .seat_idx_o     (seat_idx[r]),
      .score_o        (score[r]),
      .occ_o          (occ[r]),
      .players_o      (players[r])
    );
  end

  // Result of the executing transaction.
  always_comb begin
    logic                           any_hit, any_open, any_full;
    logic [31:0]                    row_acc, seat_acc;
    logic [SCORE_W-1:0]             rd_score;
    logic [SEATS-1:0]               rd_occ;
    logic [SEATS-1:0][PLAYER_W-1:0] rd_players;
    logic [3:0]                     vld;
    logic [3:0][PLAYER_W-1:0]       seat_pl;

    any_hit    = 1'b0;
    any_open   = 1'b0;
    any_full   = 1'b0;
    row_acc    = '0;
    seat_acc   = '0;
    rd_score   = '0;
    rd_occ     = '0;
    rd_players = '0;
    vld        = '0;
    seat_pl    = '0;

    // At most one cell reports a hit, so the landing row is an OR.
    for (int r = 0; r < ROWS; r++) begin
      if (flags[r].hit) begin
        any_hit  = 1'b1;
        any_open = flags[r].opened;
        any_full = flags[r].full;
        row_acc  = row_acc | 32'(r);
        seat_acc = seat_acc | 32'(seat_idx[r]);
      end
      if (32'(r) == 32'(item_q.row_select)) begin
        rd_score   = score[r];
        rd_occ     = occ[r];
        rd_players = players[r];
      end
    end

    // The read shows only the first four seats; empty ones read as zero.
    for (int k = 0; k < 4; k++) begin
      if (k < SEATS) begin
        if (rd_occ[k]) begin
          vld[k]     = 1'b1;
          seat_pl[k] = rd_players[k];
        end
      end
    end

    out_d = '0;
    out_d.status = ST_DONE;
    unique case (item_q.operation)
      OP_INSERT: begin
        if (!item_q.enabled) begin
          out_d.status = ST_SKIPPED;
        end else if (!any_hit) begin
          out_d.status = ST_BELOW;
        end else if (any_full) begin
          out_d.status = ST_FULL;
        end else begin
          out_d.status      = ST_PLACED;
          out_d.placed_row  = row_acc[1:0];
          out_d.placed_seat = any_open ? 2'd0 : seat_acc[1:0];
        end
      end
      OP_READ: begin
        out_d.row_score  = rd_score;
        out_d.seat_valid = vld;
        out_d.seat_0     = seat_pl[0];
        out_d.seat_1     = seat_pl[1];
        out_d.seat_2     = seat_pl[2];
        out_d.seat_3     = seat_pl[3];
      end
      default: begin
        out_d.status = ST_DONE;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/trpi_checker.sv =====
// ----------------------------------------------------------------------------
// trpi_checker
// Port-level checks for the tied-rank podium insert block, attached to the
// top level by a bind statement.
// ----------------------------------------------------------------------------
module trpi_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input trpi_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input trpi_pkg::out_t out_data_o
);
  import trpi_pkg::*;

  // A stalled result transaction stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Only one transaction is held at a time after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted before the first executed");

  // Placement fields are zero unless the player was seated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_PLACED) |->
      (out_data_o.placed_row == 2'd0) && (out_data_o.placed_seat == 2'd0))
    else $error("placement reported without a placed status");

  // An empty seat reads as player zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.seat_valid[0] || (out_data_o.seat_0 == '0)) &&
      (out_data_o.seat_valid[1] || (out_data_o.seat_1 == '0)) &&
      (out_data_o.seat_valid[2] || (out_data_o.seat_2 == '0)) &&
      (out_data_o.seat_valid[3] || (out_data_o.seat_3 == '0)))
    else $error("empty seat shows a player");

endmodule

bind tied_rank_podium_insert_top trpi_checker u_trpi_checker (.*);
